// ===== rtl/qse_pkg.sv =====
// Shared types and constants for the quicksort engine.
// No dependencies; quicksort_engine_core and qse_sorter import this package.
package qse_pkg;

    localparam int VALUE_W   = 32;   // element value field on both streams
    localparam int INDEX_W   = 10;   // read index field
    localparam int TOTAL_W   = 11;   // element_total result field
    localparam int SWAP_W    = 19;   // swap_count result field
    localparam int PASS_W    = 20;   // internal pass counter, wraps
    localparam int S_TDATA_W = 48;   // value + index, padded to bytes
    localparam int M_TDATA_W = 64;   // result fields, padded to bytes

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Status from the sort sequencer back to the stream front end
    typedef struct packed {
        logic busy;   // sequencer is running a sort
        logic pass;   // one element passed the pivot test this cycle
    } sort_stat_t;

endpackage

// ===== rtl/quicksort_engine_core.sv =====
// Top level of the quicksort engine: stream front end, set bookkeeping and
// the output register. Uses qse_pkg, qse_elem_ram, qse_sorter (with qse_range_stack).
//
// Load items (tuser = 0) append one signed element each and are taken at one
// per cycle while the front end is idle and no untaken result waits in the
// output register; a load item with tlast set closes the set and starts an
// in-place ascending sort, during which tready stays low. The sort runs Lomuto
// partitions with the last element as pivot, using one signed compare and an
// element RAM with one write port: each partition fetches and latches the
// pivot, reads each scanned element and tests it against the pivot, swaps a
// passing element in two writes, then writes the pivot into place and goes
// on with the smaller side or a range taken off the stack. Read items
// (tuser = 1) read the RAM, then load the output register, and return the
// element at tdata index together with the set size, the count of
// pivot-test passes (low 19 bits of a 20-bit wrapping counter) and the
// overflow flag. A load beyond CAPACITY is dropped and sets overflow; the
// count, the pass counter and overflow clear on the first load of a new set.
// The element RAM needs no clearing after reset.
module quicksort_engine_core #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] value, [41:32] index, [47:42] zero
    input  logic [qse_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,   // last load of the set
    input  logic                           s_axis_tuser,   // [0] mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] sorted_value, [42:32] element_total, [61:43] swap_count,
    // [62] overflow, [63] zero
    output logic [qse_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tuser    // [0] index_valid
);
    import qse_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IN_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int TW   = (CW > TOTAL_W) ? CW : TOTAL_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RDW  = 2'd1;   // wait for the RAM read of a read item
    localparam logic [1:0] ST_SORT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg;
    logic [PASS_W-1:0] pass_reg;
    logic              ovf_reg;
    logic              pend_reg;     // next load opens a new set
    logic              start_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic               out_ok_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [SWAP_W-1:0]  out_swap_reg;
    logic               out_ovf_reg;

    logic               in_acc, ld_acc, rd_acc, out_take, sorting;
    logic [VALUE_W-1:0] in_value;
    logic [INDEX_W-1:0] in_index;
    logic signed [IN_W-1:0]       val_low;
    logic signed [DATA_WIDTH-1:0] ld_data;
    logic [CW-1:0]      cnt_eff;
    logic               has_room;
    logic [CMPW-1:0]    idx_ext, cnt_ext;
    logic               idx_ok;
    logic [TW-1:0]      total_ext;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_wa, ram_ra, ram_rb;
    logic signed [DATA_WIDTH-1:0] ram_wd, ram_rd_a, ram_rd_b;

    logic                         srt_re, srt_we;
    logic [AW-1:0]                srt_ra, srt_rb, srt_wa;
    logic signed [DATA_WIDTH-1:0] srt_wd;
    sort_stat_t                   srt_stat;

    // Stream handshake and field unpacking
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign ld_acc   = in_acc && (s_axis_tuser == MODE_LOAD);
    assign rd_acc   = in_acc && (s_axis_tuser == MODE_READ);
    assign out_take = out_valid_reg && m_axis_tready;
    assign sorting  = (state_reg == ST_SORT);

    assign in_value = s_axis_tdata[VALUE_W-1:0];
    assign in_index = s_axis_tdata[VALUE_W +: INDEX_W];

    // Keep the low element bits and sign-extend to the storage width
    assign val_low = in_value[IN_W-1:0];
    assign ld_data = DATA_WIDTH'(val_low);

    // A pending new set counts as empty for the load that opens it
    assign cnt_eff  = pend_reg ? '0 : count_reg;
    assign has_room = (cnt_eff < CW'(CAPACITY));

    // count never exceeds CAPACITY, so this also bounds the RAM address
    assign idx_ext   = CMPW'(in_index);
    assign cnt_ext   = CMPW'(count_reg);
    assign idx_ok    = (idx_ext < cnt_ext);
    assign total_ext = TW'(count_reg);

    // RAM ports belong to the sequencer while a sort runs
    assign ram_re = sorting ? srt_re : rd_acc;
    assign ram_ra = sorting ? srt_ra : idx_ext[AW-1:0];
    assign ram_rb = srt_rb;
    assign ram_we = sorting ? srt_we : (ld_acc && has_room);
    assign ram_wa = sorting ? srt_wa : cnt_eff[AW-1:0];
    assign ram_wd = sorting ? srt_wd : ld_data;

    qse_elem_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .wa   (ram_wa),
        .wd   (ram_wd),
        .re   (ram_re),
        .ra   (ram_ra),
        .rb   (ram_rb),
        .rd_a (ram_rd_a),
        .rd_b (ram_rd_b)
    );

    qse_sorter #(
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .count (count_reg),
        .rd_a  (ram_rd_a),
        .rd_b  (ram_rd_b),
        .re    (srt_re),
        .ra    (srt_ra),
        .rb    (srt_rb),
        .we    (srt_we),
        .wa    (srt_wa),
        .wd    (srt_wd),
        .stat  (srt_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rd_acc)
                begin
                    state_next = ST_RDW;
                end
                else if (ld_acc && s_axis_tlast)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_RDW:
            begin
                state_next = ST_IDLE;
            end
            ST_SORT:
            begin
                // start_reg covers the cycle before the sequencer turns busy
                if (!start_reg && !srt_stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b1;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= ld_acc && s_axis_tlast;

            if (ld_acc)
            begin
                // Open a new set on the first load after reset or after a sort
                pend_reg  <= s_axis_tlast;
                count_reg <= has_room ? (cnt_eff + 1'b1) : cnt_eff;
                ovf_reg   <= (ovf_reg && !pend_reg) || !has_room;
                if (pend_reg)
                begin
                    pass_reg <= '0;
                end
            end
            else if (srt_stat.pass)
            begin
                pass_reg <= pass_reg + 1'b1;
            end

            if (state_reg == ST_RDW)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: status on accept, element in the following cycle
    always_ff @(posedge clk)
    begin
        if (rd_acc)
        begin
            out_ok_reg    <= idx_ok;
            out_total_reg <= total_ext[TOTAL_W-1:0];
            out_swap_reg  <= pass_reg[SWAP_W-1:0];
            out_ovf_reg   <= ovf_reg;
        end
        if (state_reg == ST_RDW)
        begin
            out_data_reg <= out_ok_reg ? VALUE_W'(ram_rd_a) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {1'b0, out_ovf_reg, out_swap_reg, out_total_reg, out_data_reg};

`ifndef SYNTHESIS
    a_busy_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        srt_stat.busy |-> (state_reg == ST_SORT))
        else $error("sequencer busy outside the sort phase");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDW) |=> m_axis_tvalid)
        else $error("read item produced no result");

    a_pass_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SORT && !ld_acc) |=> $stable(pass_reg))
        else $error("pass counter moved outside a sort or set start");
`endif

endmodule

// ===== rtl/qse_elem_ram.sv =====
// Element store: one write port, two read ports with registered read data.
// No package dependency; contents are undefined until written.
module qse_elem_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        wa,
    input  logic signed [DW-1:0] wd,
    input  logic                 re,
    input  logic [AW-1:0]        ra,
    input  logic [AW-1:0]        rb,
    output logic signed [DW-1:0] rd_a,
    output logic signed [DW-1:0] rd_b
);

    logic signed [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // Read data holds until the next read strobe
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_a <= mem[ra];
            rd_b <= mem[rb];
        end
    end

endmodule

// ===== rtl/qse_range_stack.sv =====
// Stack of pending {lo, hi} ranges that replaces recursion in the sort.
// No package dependency; slots are scratch and are not reset.
module qse_range_stack #(
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          pop,
    input  logic [AW-1:0] push_lo,
    input  logic [AW-1:0] push_hi,
    output logic [AW-1:0] top_lo,
    output logic [AW-1:0] top_hi,
    output logic          empty
);

    // The larger side is always stacked, so the depth never exceeds log2 of the set size
    localparam int DEPTH = AW + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int SPW   = $clog2(DEPTH + 1);

    logic [2*AW-1:0] slot_reg [DEPTH];
    logic [SPW-1:0]  sp_reg;
    logic [SPW-1:0]  sp_m1;

    assign sp_m1             = sp_reg - 1'b1;
    assign {top_lo, top_hi}  = slot_reg[sp_m1[IW-1:0]];
    assign empty             = (sp_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (push)
        begin
            sp_reg <= sp_reg + 1'b1;
        end
        else if (pop)
        begin
            sp_reg <= sp_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[sp_reg[IW-1:0]] <= {push_lo, push_hi};
        end
    end

`ifndef SYNTHESIS
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (sp_reg < SPW'(DEPTH)))
        else $error("range stack pushed while full");
`endif

endmodule

// ===== rtl/qse_sorter.sv =====
// Sort sequencer: Lomuto partitioning over the element store with one shared
// signed compare, driving the RAM ports and the range stack. Uses qse_pkg.
module qse_sorter #(
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [CW-1:0]                count,
    input  logic signed [DATA_WIDTH-1:0] rd_a,
    input  logic signed [DATA_WIDTH-1:0] rd_b,
    output logic                         re,
    output logic [AW-1:0]                ra,
    output logic [AW-1:0]                rb,
    output logic                         we,
    output logic [AW-1:0]                wa,
    output logic signed [DATA_WIDTH-1:0] wd,
    output qse_pkg::sort_stat_t          stat
);
    import qse_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PIV  = 4'd1;   // fetch pivot at hi
    localparam logic [3:0] S_PIVW = 4'd2;   // latch pivot, seed i and j
    localparam logic [3:0] S_RD   = 4'd3;   // fetch elements at j and i
    localparam logic [3:0] S_CMP  = 4'd4;   // pivot test, write store[i]
    localparam logic [3:0] S_SWJ  = 4'd5;   // finish swap, write store[j]
    localparam logic [3:0] S_FIN  = 4'd6;   // fetch store[i] and pivot slot
    localparam logic [3:0] S_FSW1 = 4'd7;   // write pivot into place
    localparam logic [3:0] S_FSW2 = 4'd8;   // write store[i] to hi, pick next range
    localparam logic [3:0] S_POP  = 4'd9;   // take a stacked range or finish

    logic [3:0]                   state_reg, state_next;
    logic [AW-1:0]                lo_reg, hi_reg, i_reg, j_reg;
    logic signed [DATA_WIDTH-1:0] pivot_reg;

    logic [AW-1:0] i_inc, j_inc, i_dec;
    logic [AW-1:0] left_sz, right_sz;
    logic [CW-1:0] cnt_m1;
    logic          passes, left_small, left_go, right_go, cont;
    logic          push, pop, stk_empty;
    logic [AW-1:0] push_lo, push_hi, top_lo, top_hi;

    assign i_inc      = i_reg + 1'b1;
    assign j_inc      = j_reg + 1'b1;
    assign i_dec      = i_reg - 1'b1;
    assign cnt_m1     = count - 1'b1;
    assign passes     = (rd_a <= pivot_reg);
    assign left_sz    = i_reg - lo_reg;
    assign right_sz   = hi_reg - i_reg;
    assign left_small = (left_sz < right_sz);
    assign left_go    = (left_sz > AW'(1));
    assign right_go   = (right_sz > AW'(1));
    assign cont       = left_small ? left_go : right_go;

    // Stack the larger side, keep working on the smaller one
    assign push    = (state_reg == S_FSW2) && (left_small ? right_go : left_go);
    assign push_lo = left_small ? i_inc : lo_reg;
    assign push_hi = left_small ? hi_reg : i_dec;
    assign pop     = (state_reg == S_POP) && !stk_empty;

    qse_range_stack #(
        .AW (AW)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .push_lo (push_lo),
        .push_hi (push_hi),
        .top_lo  (top_lo),
        .top_hi  (top_hi),
        .empty   (stk_empty)
    );

    always_comb
    begin
        re = 1'b0;
        ra = i_reg;
        rb = hi_reg;
        we = 1'b0;
        wa = i_reg;
        wd = rd_a;
        case (state_reg)
            S_PIV:
            begin
                re = 1'b1;
                ra = hi_reg;
            end
            S_RD:
            begin
                re = 1'b1;
                ra = j_reg;
                rb = i_reg;
            end
            S_FIN:
            begin
                re = 1'b1;
            end
            S_CMP:
            begin
                we = passes;
            end
            S_SWJ:
            begin
                we = 1'b1;
                wa = j_reg;
                wd = rd_b;
            end
            S_FSW1:
            begin
                we = 1'b1;
                wd = rd_b;
            end
            S_FSW2:
            begin
                we = 1'b1;
                wa = hi_reg;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (count > CW'(1)))
                begin
                    state_next = S_PIV;
                end
            end
            S_PIV:  state_next = S_PIVW;
            S_PIVW: state_next = S_RD;
            S_RD:   state_next = S_CMP;
            S_CMP:
            begin
                if (passes)
                begin
                    state_next = S_SWJ;
                end
                else if (j_inc == hi_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_SWJ:  state_next = (j_inc == hi_reg) ? S_FIN : S_RD;
            S_FIN:  state_next = S_FSW1;
            S_FSW1: state_next = S_FSW2;
            S_FSW2: state_next = cont ? S_PIV : S_POP;
            S_POP:  state_next = stk_empty ? S_IDLE : S_PIV;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Range and scan indices and the pivot; pure datapath, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                lo_reg <= '0;
                hi_reg <= cnt_m1[AW-1:0];
            end
            S_PIVW:
            begin
                pivot_reg <= rd_a;
                i_reg     <= lo_reg;
                j_reg     <= lo_reg;
            end
            S_CMP:
            begin
                if (!passes)
                begin
                    j_reg <= j_inc;
                end
            end
            S_SWJ:
            begin
                i_reg <= i_inc;
                j_reg <= j_inc;
            end
            S_FSW2:
            begin
                if (left_small)
                begin
                    hi_reg <= i_dec;
                end
                else
                begin
                    lo_reg <= i_inc;
                end
            end
            S_POP:
            begin
                lo_reg <= top_lo;
                hi_reg <= top_hi;
            end
            default:
            begin
                pivot_reg <= pivot_reg;
            end
        endcase
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.pass = (state_reg == S_CMP) && passes;

`ifndef SYNTHESIS
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP || state_reg == S_SWJ)
        |-> (i_reg <= j_reg) && (j_reg < hi_reg))
        else $error("partition scan indices out of order");

    a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PIV) |-> (lo_reg < hi_reg))
        else $error("partition started on a range of fewer than two elements");
`endif

endmodule
